@@ rtl/ctc_pkg.sv @@
// Shared types and constants of the container trace classifier.
package ctc_pkg;

    // Input transaction layout: mode in bit 0, value above it, padded to bytes.
    localparam int unsigned MODE_W    = 1;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned IN_DATA_W = 40;

    // Output transaction layout: verdict in the low bits, overflow above it.
    localparam int unsigned VERDICT_W  = 3;
    localparam int unsigned OUT_DATA_W = 8;

    // Operation codes carried in the mode field.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Positions of the consistent flags of the three models.
    localparam int unsigned FLAG_STACK = 0;
    localparam int unsigned FLAG_QUEUE = 1;
    localparam int unsigned FLAG_PRIO  = 2;
    localparam int unsigned NUM_MODELS = 3;

    localparam logic [NUM_MODELS-1:0] FLAGS_NONE       = 3'b000;
    localparam logic [NUM_MODELS-1:0] FLAGS_ONLY_STACK = 3'b001;
    localparam logic [NUM_MODELS-1:0] FLAGS_ONLY_QUEUE = 3'b010;
    localparam logic [NUM_MODELS-1:0] FLAGS_ONLY_PRIO  = 3'b100;
    localparam logic [NUM_MODELS-1:0] FLAGS_ALL        = 3'b111;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_IMPOSSIBLE = 3'd0,
        VERDICT_STACK      = 3'd1,
        VERDICT_QUEUE      = 3'd2,
        VERDICT_PRIO       = 3'd3,
        VERDICT_UNSURE     = 3'd4
    } t_verdict;

    // How a row of cells takes in a pushed value.
    typedef enum logic [1:0] {
        KIND_LIFO,
        KIND_FIFO,
        KIND_PRIO
    } t_kind;

    // What a row reports to the control logic about its front cell.
    typedef struct packed {
        logic head_valid;
        logic head_match;
        logic full;
    } t_chain_status;

endpackage

@@ rtl/ctc_cell.sv @@
// One storage cell of a container row: holds a value and shifts with its neighbors.
module ctc_cell #(
    parameter ctc_pkg::t_kind KIND       = ctc_pkg::KIND_LIFO,
    parameter int unsigned    VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_pop,
    input  logic                  i_clear,
    input  logic [VALUE_BITS-1:0] i_key,
    input  logic [VALUE_BITS-1:0] i_left_data,
    input  logic                  i_left_valid,
    input  logic                  i_left_keep,
    input  logic [VALUE_BITS-1:0] i_right_data,
    input  logic                  i_right_valid,
    output logic [VALUE_BITS-1:0] o_data,
    output logic                  o_valid,
    output logic                  o_keep
);
    import ctc_pkg::*;

    logic [VALUE_BITS-1:0] r_data;
    logic [VALUE_BITS-1:0] n_data;
    logic                  r_valid;
    logic                  n_valid;
    logic                  w_keep;

    // The cell keeps its place in a descending row when it is at least the new key.
    assign w_keep = r_valid && ($signed(r_data) >= $signed(i_key));

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_clear) begin
            n_valid = 1'b0;
        end else if (i_push) begin
            case (KIND)
                KIND_LIFO: begin
                    n_data  = i_left_data;
                    n_valid = i_left_valid;
                end
                KIND_FIFO: begin
                    if (!r_valid && i_left_valid) begin
                        n_data  = i_key;
                        n_valid = 1'b1;
                    end
                end
                KIND_PRIO: begin
                    if (!w_keep) begin
                        if (i_left_keep) begin
                            n_data  = i_key;
                            n_valid = 1'b1;
                        end else begin
                            n_data  = i_left_data;
                            n_valid = i_left_valid;
                        end
                    end
                end
                default: begin
                    n_data  = r_data;
                    n_valid = r_valid;
                end
            endcase
        end else if (i_pop) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_keep  = w_keep;

endmodule

@@ rtl/ctc_chain.sv @@
// A row of cells that models one container, with its front cell at index zero.
module ctc_chain #(
    parameter ctc_pkg::t_kind KIND       = ctc_pkg::KIND_LIFO,
    parameter int unsigned    DEPTH      = 64,
    parameter int unsigned    VALUE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic                   i_pop,
    input  logic                   i_clear,
    input  logic [VALUE_BITS-1:0]  i_key,
    output ctc_pkg::t_chain_status o_status
);
    import ctc_pkg::*;

    logic [VALUE_BITS-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]      w_valid;
    logic [DEPTH-1:0]      w_keep;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VALUE_BITS-1:0] w_left_data;
        logic                  w_left_valid;
        logic                  w_left_keep;
        logic [VALUE_BITS-1:0] w_right_data;
        logic                  w_right_valid;

        // The front cell sees the incoming key as its left neighbor.
        if (i == 0) begin : g_front
            assign w_left_data  = i_key;
            assign w_left_valid = 1'b1;
            assign w_left_keep  = 1'b1;
        end else begin : g_inner_left
            assign w_left_data  = w_data[i-1];
            assign w_left_valid = w_valid[i-1];
            assign w_left_keep  = w_keep[i-1];
        end

        if (i == DEPTH - 1) begin : g_back
            assign w_right_data  = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner_right
            assign w_right_data  = w_data[i+1];
            assign w_right_valid = w_valid[i+1];
        end

        ctc_cell #(
            .KIND       (KIND),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_push        (i_push),
            .i_pop         (i_pop),
            .i_clear       (i_clear),
            .i_key         (i_key),
            .i_left_data   (w_left_data),
            .i_left_valid  (w_left_valid),
            .i_left_keep   (w_left_keep),
            .i_right_data  (w_right_data),
            .i_right_valid (w_right_valid),
            .o_data        (w_data[i]),
            .o_valid       (w_valid[i]),
            .o_keep        (w_keep[i])
        );
    end

    assign o_status.head_valid = w_valid[0];
    assign o_status.head_match = w_valid[0] && (w_data[0] == i_key);
    assign o_status.full       = w_valid[DEPTH-1];

    // Occupied cells always form an unbroken run starting at the front.
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("ctc_chain: occupied cells are not contiguous from the front");

    // A full row cannot report an empty front cell.
    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> o_status.head_valid)
        else $error("ctc_chain: full row with an empty front cell");

    // A clear empties the whole row on the next cycle.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (w_valid == '0))
        else $error("ctc_chain: row not empty after a clear");

endmodule

@@ rtl/container_trace_classifier_top.sv @@
// Top level of the container trace classifier: three cell rows and the verdict logic.
//
// The block watches a trace of push and pop transactions on the slave stream and
// decides whether a stack, a queue or a max-priority queue could have produced it.
// Each slave transaction carries the operation in s_axis_tdata[0] (0 push, 1 pop),
// the signed 32-bit value in s_axis_tdata[32:1], and s_axis_tlast marks the final
// operation of a trace. A pop carries the value that the container returned.
// Three rows of DEPTH cells model the containers side by side; every cell shifts
// or loads in the same cycle, so the block takes one transaction per clock while
// the slave side is not stalled. When the transaction with tlast is accepted, one
// verdict transaction leaves on the master stream in the following cycle:
// m_axis_tdata[2:0] holds the verdict (0 impossible, 1 stack, 2 queue, 3 priority
// queue, 4 not sure) and bit 3 says whether a push found the containers full. All
// model state is then cleared, so the next transaction starts a fresh trace. The
// verdict sits in an output register; while it waits and the receiver holds
// m_axis_tready low, the slave side stalls, otherwise new transactions are taken
// in the same cycle the verdict leaves. Synchronous reset empties all rows, sets
// the consistent flags and drops any pending verdict.
module container_trace_classifier_top #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0 up: mode (1), value (32), zero padding (7).
    input  logic [ctc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0 up: verdict (3), overflow (1), zero padding (4).
    output logic [ctc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import ctc_pkg::*;

    logic                   w_accept;
    logic                   w_mode;
    logic [VALUE_W-1:0]     w_value;
    logic [VALUE_BITS-1:0]  w_key;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_end;
    t_chain_status          w_lifo;
    t_chain_status          w_fifo;
    t_chain_status          w_prio;
    logic [NUM_MODELS-1:0]  r_flags;
    logic [NUM_MODELS-1:0]  n_flags;
    logic                   r_overflow;
    logic                   n_overflow;
    t_verdict               w_verdict;
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_mode        = s_axis_tdata[0];
    assign w_value       = s_axis_tdata[VALUE_W:MODE_W];

    // The value is taken as a signed number of VALUE_BITS bits.
    if (VALUE_BITS <= VALUE_W) begin : g_key_trunc
        assign w_key = w_value[VALUE_BITS-1:0];
    end else begin : g_key_ext
        assign w_key = {{(VALUE_BITS - VALUE_W){w_value[VALUE_W-1]}}, w_value};
    end

    assign w_push = w_accept && (w_mode == OP_PUSH);
    assign w_pop  = w_accept && (w_mode == OP_POP);
    assign w_end  = w_accept && s_axis_tlast;

    // A row that is full ignores the push; the overflow flag records it.
    ctc_chain #(
        .KIND (KIND_LIFO), .DEPTH (DEPTH), .VALUE_BITS (VALUE_BITS)
    ) u_lifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push && !w_lifo.full),
        .i_pop    (w_pop),
        .i_clear  (w_end),
        .i_key    (w_key),
        .o_status (w_lifo)
    );

    ctc_chain #(
        .KIND (KIND_FIFO), .DEPTH (DEPTH), .VALUE_BITS (VALUE_BITS)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push && !w_fifo.full),
        .i_pop    (w_pop),
        .i_clear  (w_end),
        .i_key    (w_key),
        .o_status (w_fifo)
    );

    ctc_chain #(
        .KIND (KIND_PRIO), .DEPTH (DEPTH), .VALUE_BITS (VALUE_BITS)
    ) u_prio (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push && !w_prio.full),
        .i_pop    (w_pop),
        .i_clear  (w_end),
        .i_key    (w_key),
        .o_status (w_prio)
    );

    // A pop clears a model's flag when its front is empty or holds another value.
    always_comb begin
        n_flags = r_flags;
        if (w_pop) begin
            if (!w_lifo.head_match) begin
                n_flags[FLAG_STACK] = 1'b0;
            end
            if (!w_fifo.head_match) begin
                n_flags[FLAG_QUEUE] = 1'b0;
            end
            if (!w_prio.head_match) begin
                n_flags[FLAG_PRIO] = 1'b0;
            end
        end
        n_overflow = r_overflow
                   || (w_push && (w_lifo.full || w_fifo.full || w_prio.full));
    end

    // The verdict includes the effect of the final operation itself.
    always_comb begin
        case (n_flags)
            FLAGS_NONE:       w_verdict = VERDICT_IMPOSSIBLE;
            FLAGS_ONLY_STACK: w_verdict = VERDICT_STACK;
            FLAGS_ONLY_QUEUE: w_verdict = VERDICT_QUEUE;
            FLAGS_ONLY_PRIO:  w_verdict = VERDICT_PRIO;
            default:          w_verdict = VERDICT_UNSURE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= FLAGS_ALL;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
        end else begin
            if (w_end) begin
                r_flags     <= FLAGS_ALL;
                r_overflow  <= 1'b0;
                r_out_valid <= 1'b1;
                r_out_data  <= {{(OUT_DATA_W - VERDICT_W - 1){1'b0}}, n_overflow,
                                w_verdict};
            end else begin
                r_flags    <= n_flags;
                r_overflow <= n_overflow;
                if (m_axis_tready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The three rows see the same pushes and pops, so they fill up together.
    a_rows_fill_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lifo.full == w_fifo.full) && (w_fifo.full == w_prio.full))
        else $error("ctc_top: container rows disagree on occupancy");

    // Ending a trace restores the flags for the next one.
    a_end_restores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |=> (r_flags == FLAGS_ALL) && !r_overflow)
        else $error("ctc_top: trace state not restored after the last operation");

    // A verdict appears only after an operation that ends a trace.
    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_end))
        else $error("ctc_top: verdict without a final operation");

endmodule

@@ tb/sv/ctc_verdict_checker.sv @@
// Verdict checker for the container trace classifier: tracks both streams and predicts verdicts.
module ctc_verdict_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [ctc_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic                           i_in_last,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [ctc_pkg::OUT_DATA_W-1:0] i_out_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import ctc_pkg::*;

    localparam int unsigned DEPTH = 64;

    typedef struct {
        t_verdict verdict;
        logic     overflow;
    } t_verdict_rec;

    // Shadow copies of the three containers of the current trace.
    logic signed [VALUE_W-1:0] lifo_cells [DEPTH];
    logic signed [VALUE_W-1:0] fifo_cells [DEPTH];
    logic signed [VALUE_W-1:0] prio_cells [DEPTH];   // ascending, maximum on top
    int unsigned               lifo_fill;
    int unsigned               fifo_head;
    int unsigned               fifo_tail;
    int unsigned               fifo_fill;
    int unsigned               prio_fill;
    logic [NUM_MODELS-1:0]     still_fits;
    logic                      full_hit;

    t_verdict_rec              verdicts_due [$];

    task automatic clear_trace();
        lifo_fill  = 0;
        fifo_head  = 0;
        fifo_tail  = 0;
        fifo_fill  = 0;
        prio_fill  = 0;
        still_fits = FLAGS_ALL;
        full_hit   = 1'b0;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        clear_trace();
    end

    always @(posedge i_clk) begin : track
        logic signed [VALUE_W-1:0] v;
        int unsigned               i;
        t_verdict_rec              got;
        t_verdict_rec              want;
        if (!i_rst_n) begin
            clear_trace();
            verdicts_due.delete();
        end else begin
            // The output side is checked first: a verdict leaving now is always
            // older than one predicted from an input taken at the same edge.
            if (i_out_valid && i_out_ready) begin
                got.verdict  = t_verdict'(i_out_data[VERDICT_W-1:0]);
                got.overflow = i_out_data[VERDICT_W];
                if (verdicts_due.size() == 0) begin
                    $display({"%0t: verdict with none due: expected nothing, ",
                              "actual verdict %0d overflow %0b"},
                             $time, got.verdict, got.overflow);
                    o_fail_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.verdict !== want.verdict) begin
                        $display("%0t: verdict mismatch: expected %0d, actual %0d",
                                 $time, want.verdict, got.verdict);
                        o_fail_count++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $display("%0t: overflow mismatch: expected %0b, actual %0b",
                                 $time, want.overflow, got.overflow);
                        o_fail_count++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                v = i_in_data[MODE_W +: VALUE_W];
                if (i_in_data[0] == OP_PUSH) begin
                    if (lifo_fill < DEPTH) begin
                        lifo_cells[lifo_fill] = v;
                        lifo_fill++;
                    end else begin
                        full_hit = 1'b1;
                    end
                    if (fifo_fill < DEPTH) begin
                        fifo_cells[fifo_tail] = v;
                        fifo_tail = (fifo_tail + 1) % DEPTH;
                        fifo_fill++;
                    end else begin
                        full_hit = 1'b1;
                    end
                    if (prio_fill < DEPTH) begin
                        i = prio_fill;
                        while (i > 0 && prio_cells[i-1] > v) begin
                            prio_cells[i] = prio_cells[i-1];
                            i--;
                        end
                        prio_cells[i] = v;
                        prio_fill++;
                    end else begin
                        full_hit = 1'b1;
                    end
                end else begin
                    // A pop on an empty container only clears its flag; a
                    // mismatching pop still removes the item.
                    if (lifo_fill == 0) begin
                        still_fits[FLAG_STACK] = 1'b0;
                    end else begin
                        lifo_fill--;
                        if (lifo_cells[lifo_fill] != v) still_fits[FLAG_STACK] = 1'b0;
                    end
                    if (fifo_fill == 0) begin
                        still_fits[FLAG_QUEUE] = 1'b0;
                    end else begin
                        if (fifo_cells[fifo_head] != v) still_fits[FLAG_QUEUE] = 1'b0;
                        fifo_head = (fifo_head + 1) % DEPTH;
                        fifo_fill--;
                    end
                    if (prio_fill == 0) begin
                        still_fits[FLAG_PRIO] = 1'b0;
                    end else begin
                        prio_fill--;
                        if (prio_cells[prio_fill] != v) still_fits[FLAG_PRIO] = 1'b0;
                    end
                end

                if (i_in_last) begin
                    case (still_fits)
                        FLAGS_NONE:       want.verdict = VERDICT_IMPOSSIBLE;
                        FLAGS_ONLY_STACK: want.verdict = VERDICT_STACK;
                        FLAGS_ONLY_QUEUE: want.verdict = VERDICT_QUEUE;
                        FLAGS_ONLY_PRIO:  want.verdict = VERDICT_PRIO;
                        default:          want.verdict = VERDICT_UNSURE;
                    endcase
                    want.overflow = full_hit;
                    verdicts_due.insert(verdicts_due.size(), want);
                    clear_trace();
                end
            end
        end
        o_pending = verdicts_due.size();
    end

endmodule

@@ tb/sv/tb_container_trace_classifier_top.sv @@
// Testbench top for the container trace classifier: clock, reset, trace stimulus and verdict.
module tb_container_trace_classifier_top;
    import ctc_pkg::*;

    localparam int unsigned DEPTH      = 64;
    localparam int          ITEMS      = 650;
    localparam int          MIN_TRACES = 48;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // Fields from bit 0 up: mode (1), value (32), zero padding (7).
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // Fields from bit 0 up: verdict (3), overflow (1), zero padding (4).
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;

    // Idle chances in percent for the sender and the receiver; the stimulus
    // changes them as the run moves from one phase to the next.
    int send_pct;
    int recv_pct;

    int items_sent;
    int traces_sent;

    container_trace_classifier_top #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ctc_verdict_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // The receiver decides on its ready at every falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= (recv_pct == 0) || ($urandom_range(99) >= recv_pct);
    end

    // Values come from a tiny pool (duplicates make several containers agree),
    // from the whole 32-bit range, or from the signed extremes.
    function automatic logic signed [VALUE_W-1:0] pick_value(input int sel);
        logic signed [VALUE_W-1:0] r;
        case (sel)
            0:       r = $urandom_range(3);
            1:       r = $urandom();
            default: begin
                case ($urandom_range(4))
                    0:       r = 32'sh8000_0000;
                    1:       r = 32'sh7fff_ffff;
                    2:       r = -32'sd1;
                    3:       r = 32'sd0;
                    default: r = 32'sd1;
                endcase
            end
        endcase
        return r;
    endfunction

    // Offers one operation and holds it until the slave side takes the transaction.
    task automatic send_op(input logic op, input logic signed [VALUE_W-1:0] val,
                           input logic lst);
        @(negedge i_clk);
        while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - MODE_W - VALUE_W){1'b0}}, val, op};
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (lst) traces_sent++;
    endtask

    initial begin : stimulus
        logic signed [VALUE_W-1:0] held [$];
        logic signed [VALUE_W-1:0] v;
        logic                      op;
        t_kind                     shape;
        int                        len;
        int                        vsel;
        int                        top_idx;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_rst_n       = 1'b0;
        send_pct      = 0;
        recv_pct      = 0;
        items_sent    = 0;
        traces_sent   = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // First phase: a slow sender and a receiver that stalls often.
        send_pct = 24;
        recv_pct = 55;

        // A single push leaves every container consistent.
        send_op(OP_PUSH, 32'sh7fff_ffff, 1'b1);
        // A pop from empty containers rules all of them out.
        send_op(OP_POP, 32'sd0, 1'b1);
        // Arrival order: only the queue fits.
        send_op(OP_PUSH, 32'sd1, 1'b0);
        send_op(OP_PUSH, 32'sd2, 1'b0);
        send_op(OP_POP,  32'sd1, 1'b0);
        send_op(OP_POP,  32'sd2, 1'b1);
        // Reverse order with a smaller value on top: only the stack fits.
        send_op(OP_PUSH, 32'sd2, 1'b0);
        send_op(OP_PUSH, 32'sd1, 1'b0);
        send_op(OP_POP,  32'sd1, 1'b0);
        send_op(OP_POP,  32'sd2, 1'b1);
        // Largest first: only the priority queue fits.
        send_op(OP_PUSH, 32'sd1, 1'b0);
        send_op(OP_PUSH, 32'sd3, 1'b0);
        send_op(OP_PUSH, 32'sd2, 1'b0);
        send_op(OP_POP,  32'sd3, 1'b0);
        send_op(OP_POP,  32'sd2, 1'b1);
        // Signed extremes: the most negative value must rank lowest.
        send_op(OP_PUSH, 32'sh8000_0000, 1'b0);
        send_op(OP_PUSH, 32'sh7fff_ffff, 1'b0);
        send_op(OP_POP,  32'sh7fff_ffff, 1'b0);
        send_op(OP_POP,  32'sh8000_0000, 1'b1);
        // A wrong pop value still removes the item, so the next pop finds empty.
        send_op(OP_PUSH, 32'sd5, 1'b0);
        send_op(OP_POP,  32'sd6, 1'b0);
        send_op(OP_POP,  32'sd5, 1'b1);
        // All ones round trip.
        send_op(OP_PUSH, -32'sd1, 1'b0);
        send_op(OP_POP,  -32'sd1, 1'b1);

        while (items_sent < ITEMS || traces_sent < MIN_TRACES) begin
            if (items_sent >= 2 * ITEMS / 3) begin
                send_pct = 0;
                recv_pct = 0;
            end else if (items_sent >= ITEMS / 3) begin
                send_pct = 55;
                recv_pct = 24;
            end
            held.delete();
            if (traces_sent % 20 == 10) begin
                // Fill past capacity, then one pop to end the trace.
                len = DEPTH + $urandom_range(1, 4);
                for (int k = 0; k < len; k++) send_op(OP_PUSH, $urandom(), 1'b0);
                send_op(OP_POP, $urandom(), 1'b1);
            end else if ($urandom_range(99) < 75) begin
                // A trace that one container really produced, now and then
                // with a corrupted pop value.
                shape = t_kind'($urandom_range(2));
                len   = $urandom_range(1, 24);
                vsel  = $urandom_range(2);
                for (int k = 0; k < len; k++) begin
                    if (held.size() == 0 || $urandom_range(99) < 50) begin
                        op = OP_PUSH;
                        v  = pick_value(vsel);
                        held.insert(held.size(), v);
                    end else begin
                        op = OP_POP;
                        case (shape)
                            KIND_LIFO: v = held.pop_back();
                            KIND_FIFO: v = held.pop_front();
                            default: begin
                                top_idx = 0;
                                foreach (held[j]) if (held[j] > held[top_idx]) top_idx = j;
                                v = held[top_idx];
                                held.delete(top_idx);
                            end
                        endcase
                        if ($urandom_range(99) < 4) v = v ^ (32'sd1 << $urandom_range(31));
                    end
                    send_op(op, v, k == len - 1);
                end
            end else begin
                // Noise: random operations, including pops from empty containers.
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    send_op(logic'($urandom_range(1)), pick_value($urandom_range(2)),
                            k == len - 1);
                end
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_container_trace_classifier_top: done, clean");
        end else begin
            $display("tb_container_trace_classifier_top: done, errors");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("tb_container_trace_classifier_top: done, errors");
        $finish;
    end

endmodule

@@ container_trace_classifier_top.f @@
rtl/ctc_pkg.sv
rtl/ctc_cell.sv
rtl/ctc_chain.sv
rtl/container_trace_classifier_top.sv
tb/sv/ctc_verdict_checker.sv
tb/sv/tb_container_trace_classifier_top.sv
